// ===== src/jbp_pkg.sv =====
// Shared types, constants and helpers for the PCM jitter buffer with prefill.
package jbp_pkg;

  // Ring geometry
  localparam int RING_FRAMES = 8192;
  localparam int IDX_W       = $clog2(RING_FRAMES);
  localparam int LVL_W       = $clog2(RING_FRAMES + 1);
  localparam int FRAME_W     = 32;
  localparam int BYTES_W     = 16;
  localparam int PKT_FRAMES_W = BYTES_W - 2;
  localparam int CNT_W       = 32;
  localparam int NUM_CNT     = 8;

  localparam logic [LVL_W-1:0] RING_LVL      = LVL_W'(RING_FRAMES);
  localparam logic [IDX_W-1:0] RING_LAST     = IDX_W'(RING_FRAMES - 1);
  localparam logic [LVL_W-1:0] PREFILL_RESET = LVL_W'(5120);

  // Event counter slots
  localparam int CNT_PACKETS       = 0;
  localparam int CNT_BYTES         = 1;
  localparam int CNT_BAD           = 2;
  localparam int CNT_OVERRUNS      = 3;
  localparam int CNT_DROPPED       = 4;
  localparam int CNT_UNDERRUNS     = 5;
  localparam int CNT_PREFILL_WAITS = 6;
  localparam int CNT_STARTS        = 7;

  // Read selectors beyond the event counters
  localparam logic [3:0] SEL_MIN_LEVEL = 4'd8;
  localparam logic [3:0] SEL_MAX_LEVEL = 4'd9;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_FRAME  = 3'd1,
    KIND_PULL   = 3'd2,
    KIND_START  = 3'd3,
    KIND_STOP   = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_ACCEPTED = 4'd0,
    ST_DROPPED  = 4'd1,
    ST_BAD      = 4'd2,
    ST_OVERRUN  = 4'd3,
    ST_STORED   = 4'd4,
    ST_DISCARD  = 4'd5,
    ST_AUDIO    = 4'd6,
    ST_SILENCE  = 4'd7,
    ST_UNDERRUN = 4'd8,
    ST_STARTED  = 4'd9,
    ST_HALTED   = 4'd10,
    ST_READ     = 4'd11,
    ST_IGNORED  = 4'd12
  } status_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PREFILL = 2'd1,
    MODE_PLAYING = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTES_W-1:0] packet_bytes;
    logic [FRAME_W-1:0] frame_data;
    logic [3:0]         stat_select;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] pcm_out;
    logic [LVL_W-1:0]   buffered_frames;
    logic [CNT_W-1:0]   stat_value;
  } out_item_t;

  // Per-beat result of the control unit
  typedef struct packed {
    status_t          status;
    logic [LVL_W-1:0] buffered_frames;
    logic             play;
  } ctrl_res_t;

  // Per-beat statistics update
  typedef struct packed {
    logic [NUM_CNT-1:0] inc;
    logic [BYTES_W-1:0] bytes;
    logic               start;
    logic               note_a_en;
    logic [LVL_W-1:0]   note_a;
    logic               note_b_en;
    logic [LVL_W-1:0]   note_b;
  } stat_ev_t;

  // Advance a ring index with wrap
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == RING_LAST) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

endpackage

// ===== src/jbp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module jbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register read data on request
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/jbp_stats.sv =====
// Event counters and min/max fill level tracking with counter read-out.
module jbp_stats (
  input  logic                            clk,
  input  logic                            rst,
  input  jbp_pkg::stat_ev_t               ev,
  input  logic [3:0]                      stat_select,
  input  logic [jbp_pkg::LVL_W-1:0]       fill_level,
  output logic [jbp_pkg::CNT_W-1:0]       stat_value
);

  logic [jbp_pkg::CNT_W-1:0] counters [jbp_pkg::NUM_CNT];
  logic [jbp_pkg::LVL_W-1:0] min_level;
  logic [jbp_pkg::LVL_W-1:0] max_level;
  logic [jbp_pkg::LVL_W-1:0] min_level_next;
  logic [jbp_pkg::LVL_W-1:0] max_level_next;
  logic [jbp_pkg::LVL_W-1:0] min_clamped;

  // Restart the window on start, then fold in up to two noted levels
  always_comb begin
    min_level_next = ev.start ? jbp_pkg::RING_LVL : min_level;
    max_level_next = ev.start ? '0 : max_level;
    if (ev.note_a_en) begin
      if (ev.note_a < min_level_next) min_level_next = ev.note_a;
      if (ev.note_a > max_level_next) max_level_next = ev.note_a;
    end
    if (ev.note_b_en) begin
      if (ev.note_b < min_level_next) min_level_next = ev.note_b;
      if (ev.note_b > max_level_next) max_level_next = ev.note_b;
    end
  end

  // Advance counters; the byte counter adds the packet length
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jbp_pkg::NUM_CNT; i++) begin
        counters[i] <= '0;
      end
      min_level <= jbp_pkg::RING_LVL;
      max_level <= '0;
    end else begin
      for (int i = 0; i < jbp_pkg::NUM_CNT; i++) begin
        if (ev.inc[i]) begin
          if (i == jbp_pkg::CNT_BYTES) begin
            counters[i] <= counters[i] + jbp_pkg::CNT_W'(ev.bytes);
          end else begin
            counters[i] <= counters[i] + 1'b1;
          end
        end
      end
      min_level <= min_level_next;
      max_level <= max_level_next;
    end
  end

  assign min_clamped = (min_level > fill_level) ? fill_level : min_level;

  // Select the value for a read beat
  always_comb begin
    if (stat_select[3] == 1'b0) begin
      stat_value = counters[stat_select[2:0]];
    end else if (stat_select == jbp_pkg::SEL_MIN_LEVEL) begin
      stat_value = jbp_pkg::CNT_W'(min_clamped);
    end else if (stat_select == jbp_pkg::SEL_MAX_LEVEL) begin
      stat_value = jbp_pkg::CNT_W'(max_level);
    end else begin
      stat_value = '0;
    end
  end

`ifndef SYNTHESIS
  // Window minimum never exceeds the ring capacity
  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    min_level <= jbp_pkg::RING_LVL)
    else $error("min level above capacity");

  // A start beat always leaves min and max equal to the noted level
  a_start_window: assert property (@(posedge clk) disable iff (rst)
    ev.start |=> (min_level == max_level))
    else $error("min/max window not restarted");

  // Maximum never exceeds the ring capacity
  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    max_level <= jbp_pkg::RING_LVL)
    else $error("max level above capacity");
`endif

endmodule

// ===== src/jbp_ctrl.sv =====
// Control unit: packet admission, ring pointers, play mode and status per beat.
module jbp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  jbp_pkg::in_item_t             item,
  input  logic                          cfg_we,
  input  logic [jbp_pkg::LVL_W-1:0]     cfg_wdata,
  output jbp_pkg::ctrl_res_t            res,
  output jbp_pkg::stat_ev_t             ev,
  output logic [jbp_pkg::LVL_W-1:0]     fill_q,
  output logic                          ram_we,
  output logic [jbp_pkg::IDX_W-1:0]     ram_waddr,
  output logic [jbp_pkg::FRAME_W-1:0]   ram_wdata,
  output logic                          ram_re,
  output logic [jbp_pkg::IDX_W-1:0]     ram_raddr
);

  jbp_pkg::mode_t mode;
  jbp_pkg::mode_t mode_next;

  logic [jbp_pkg::IDX_W-1:0]        write_index;
  logic [jbp_pkg::IDX_W-1:0]        write_index_next;
  logic [jbp_pkg::IDX_W-1:0]        read_index;
  logic [jbp_pkg::IDX_W-1:0]        read_index_next;
  logic [jbp_pkg::LVL_W-1:0]        fill_level;
  logic [jbp_pkg::LVL_W-1:0]        fill_level_next;
  logic [jbp_pkg::PKT_FRAMES_W-1:0] frames_left;
  logic [jbp_pkg::PKT_FRAMES_W-1:0] frames_left_next;
  logic                             pkt_acc;
  logic                             pkt_acc_next;
  logic [jbp_pkg::LVL_W-1:0]        prefill_frames;

  logic [jbp_pkg::PKT_FRAMES_W-1:0] hdr_frames;
  logic [jbp_pkg::LVL_W-1:0]        room;
  logic                             hdr_overrun;
  logic                             pull_go;
  logic                             pull_live;

  assign hdr_frames  = item.packet_bytes[jbp_pkg::BYTES_W-1:2];
  assign room        = jbp_pkg::RING_LVL - fill_level;
  assign hdr_overrun = (17'(hdr_frames) > 17'(room));
  assign pull_go     = (fill_level >= prefill_frames);
  assign pull_live   = (mode == jbp_pkg::MODE_PLAYING) ||
                       ((mode == jbp_pkg::MODE_PREFILL) && pull_go);

  // Next play mode
  always_comb begin
    mode_next = mode;
    if (in_accept) begin
      unique case (item.kind)
        jbp_pkg::KIND_PULL: begin
          if (pull_live) begin
            mode_next = (fill_level == '0) ? jbp_pkg::MODE_PREFILL : jbp_pkg::MODE_PLAYING;
          end
        end
        jbp_pkg::KIND_START: begin
          if (mode == jbp_pkg::MODE_STOPPED) mode_next = jbp_pkg::MODE_PREFILL;
        end
        jbp_pkg::KIND_STOP: begin
          mode_next = jbp_pkg::MODE_STOPPED;
        end
        default: ;
      endcase
    end
  end

  // Pointer, packet and status outputs of the beat
  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    fill_level_next  = fill_level;
    frames_left_next = frames_left;
    pkt_acc_next     = pkt_acc;
    res.status       = jbp_pkg::ST_IGNORED;
    res.play         = 1'b0;
    ev               = '0;
    ev.bytes         = item.packet_bytes;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    if (in_accept) begin
      unique case (item.kind)
        jbp_pkg::KIND_HEADER: begin
          pkt_acc_next     = 1'b0;
          frames_left_next = '0;
          priority if (item.packet_bytes == '0) begin
            res.status = jbp_pkg::ST_IGNORED;
          end else if (mode == jbp_pkg::MODE_STOPPED) begin
            ev.inc[jbp_pkg::CNT_DROPPED] = 1'b1;
            frames_left_next = hdr_frames;
            res.status       = jbp_pkg::ST_DROPPED;
          end else if (item.packet_bytes[1:0] != 2'b00) begin
            ev.inc[jbp_pkg::CNT_BAD] = 1'b1;
            res.status = jbp_pkg::ST_BAD;
          end else begin
            ev.inc[jbp_pkg::CNT_PACKETS] = 1'b1;
            ev.inc[jbp_pkg::CNT_BYTES]   = 1'b1;
            frames_left_next = hdr_frames;
            if (hdr_overrun) begin
              ev.inc[jbp_pkg::CNT_OVERRUNS] = 1'b1;
              res.status = jbp_pkg::ST_OVERRUN;
            end else begin
              pkt_acc_next = 1'b1;
              res.status   = jbp_pkg::ST_ACCEPTED;
            end
          end
        end
        jbp_pkg::KIND_FRAME: begin
          if ((frames_left != '0) && pkt_acc && (fill_level < jbp_pkg::RING_LVL)) begin
            ram_we           = 1'b1;
            write_index_next = jbp_pkg::ring_next(write_index);
            fill_level_next  = fill_level + 1'b1;
            res.status       = jbp_pkg::ST_STORED;
          end else begin
            res.status = jbp_pkg::ST_DISCARD;
          end
          if (frames_left != '0) frames_left_next = frames_left - 1'b1;
          // close the packet once its last frame has gone by
          pkt_acc_next = pkt_acc && (frames_left > jbp_pkg::PKT_FRAMES_W'(1));
        end
        jbp_pkg::KIND_PULL: begin
          if (mode == jbp_pkg::MODE_PREFILL) begin
            ev.note_a_en = 1'b1;
            ev.note_a    = fill_level;
            if (!pull_go) res.status = jbp_pkg::ST_SILENCE;
          end
          if (pull_live) begin
            ev.note_b_en = 1'b1;
            if (fill_level == '0) begin
              ev.inc[jbp_pkg::CNT_UNDERRUNS]     = 1'b1;
              ev.inc[jbp_pkg::CNT_PREFILL_WAITS] = 1'b1;
              ev.note_b  = fill_level;
              res.status = jbp_pkg::ST_UNDERRUN;
            end else begin
              ram_re          = 1'b1;
              read_index_next = jbp_pkg::ring_next(read_index);
              fill_level_next = fill_level - 1'b1;
              ev.note_b       = fill_level - 1'b1;
              res.status      = jbp_pkg::ST_AUDIO;
              res.play        = 1'b1;
            end
          end
        end
        jbp_pkg::KIND_START: begin
          ev.inc[jbp_pkg::CNT_STARTS] = 1'b1;
          ev.start     = 1'b1;
          ev.note_b_en = 1'b1;
          ev.note_b    = fill_level;
          if (mode == jbp_pkg::MODE_STOPPED) begin
            ev.inc[jbp_pkg::CNT_PREFILL_WAITS] = 1'b1;
            read_index_next = write_index;
            fill_level_next = '0;
            ev.note_b       = '0;
          end
          res.status = jbp_pkg::ST_STARTED;
        end
        jbp_pkg::KIND_STOP: begin
          read_index_next  = write_index;
          fill_level_next  = '0;
          pkt_acc_next     = 1'b0;
          frames_left_next = '0;
          res.status       = jbp_pkg::ST_HALTED;
        end
        jbp_pkg::KIND_READ: begin
          res.status = (item.stat_select <= jbp_pkg::SEL_MAX_LEVEL) ?
                       jbp_pkg::ST_READ : jbp_pkg::ST_IGNORED;
        end
        default: ;
      endcase
    end
    res.buffered_frames = fill_level_next;
  end

  assign fill_q              = fill_level;
  assign ram_waddr           = write_index;
  assign ram_wdata           = item.frame_data;
  assign ram_raddr           = read_index;

  // Hold state between beats, advance on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jbp_pkg::MODE_STOPPED;
      write_index <= '0;
      read_index  <= '0;
      fill_level  <= '0;
      frames_left <= '0;
      pkt_acc     <= 1'b0;
    end else if (in_accept) begin
      mode        <= mode_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
      fill_level  <= fill_level_next;
      frames_left <= frames_left_next;
      pkt_acc     <= pkt_acc_next;
    end
  end

  // Prefill threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      prefill_frames <= jbp_pkg::PREFILL_RESET;
    end else if (cfg_we) begin
      prefill_frames <= cfg_wdata;
    end
  end

`ifndef SYNTHESIS
  logic [jbp_pkg::LVL_W-1:0] ptr_dist;
  assign ptr_dist = (write_index >= read_index) ?
                    (jbp_pkg::LVL_W'(write_index) - jbp_pkg::LVL_W'(read_index)) :
                    (jbp_pkg::LVL_W'(write_index) + jbp_pkg::RING_LVL -
                     jbp_pkg::LVL_W'(read_index));

  // Fill level never exceeds the ring
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= jbp_pkg::RING_LVL)
    else $error("fill level above capacity");

  // Fill level agrees with the pointer distance, or the ring is full
  a_fill_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill_level == ptr_dist) || (fill_level == jbp_pkg::RING_LVL))
    else $error("fill level out of step with pointers");

  // An open accepted packet always has frames to come
  a_pkt_open: assert property (@(posedge clk) disable iff (rst)
    pkt_acc |-> (frames_left != '0))
    else $error("accepted packet with no frames left");
`endif

endmodule

// ===== src/pcm_jitter_buffer_prefill.sv =====
// Top level of the PCM jitter buffer with prefill: ring memory, control, statistics, output stage.
// A result is registered into the output slot in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the ring RAM takes one write or one read per beat.
// A pulled frame is read at accept and its RAM data lands with the registered result.
// Reset (synchronous, active high) clears pointers, mode, counters and the output valid flag
// at once; ring contents stay undefined and need no clearing pass.
module pcm_jitter_buffer_prefill (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jbp_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output jbp_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [jbp_pkg::LVL_W-1:0]     cfg_wdata
);

  logic                          in_accept;
  jbp_pkg::ctrl_res_t            res;
  jbp_pkg::ctrl_res_t            res_q;
  jbp_pkg::stat_ev_t             ev;
  logic [jbp_pkg::LVL_W-1:0]     fill_q;
  logic [jbp_pkg::CNT_W-1:0]     stat_value;
  logic [jbp_pkg::CNT_W-1:0]     stat_q;
  logic                          ram_we;
  logic [jbp_pkg::IDX_W-1:0]     ram_waddr;
  logic [jbp_pkg::FRAME_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [jbp_pkg::IDX_W-1:0]     ram_raddr;
  logic [jbp_pkg::FRAME_W-1:0]   ram_rdata;

  // Take a beat whenever the output slot is free or drains this cycle
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  jbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res),
    .ev        (ev),
    .fill_q    (fill_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  jbp_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .stat_select (in_item.stat_select),
    .fill_level  (fill_q),
    .stat_value  (stat_value)
  );

  jbp_ram #(
    .WIDTH (jbp_pkg::FRAME_W),
    .DEPTH (jbp_pkg::RING_FRAMES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output slot: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output slot: payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_q  <= res;
      stat_q <= (res.status == jbp_pkg::ST_READ) ? stat_value : '0;
    end
  end

  // Assemble the result beat; played frames come straight from the ring RAM
  always_comb begin
    out_item.status          = res_q.status;
    out_item.pcm_out         = res_q.play ? ram_rdata : '0;
    out_item.buffered_frames = res_q.buffered_frames;
    out_item.stat_value      = stat_q;
  end

endmodule
